[src/bounded_double_ended_queue_macros.svh]
// Assertion macros for the bounded double-ended queue checker
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication
`define BDQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bdq_pkg.sv]
// Shared constants and controller/datapath interface types for the deque
package bdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int ST_W      = 2;

  localparam logic [OP_W-1:0] OP_PUSH_LEFT  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_RIGHT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_LEFT   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_RIGHT  = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK_LEFT  = 3'd4;
  localparam logic [OP_W-1:0] OP_PEEK_RIGHT = 3'd5;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd6;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  localparam logic signed [DATA_W-1:0] EMPTY_DATA = -32'sd1;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // latch request, do push / issue first read
    logic read_done;  // capture pop/peek data, apply pop
    logic srch_addr;  // address the store from the search index
    logic srch_next;  // advance search index
    logic srch_done;  // record search outcome
    logic load_out;   // move result into the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_read;  // incoming request is a pop/peek on a non-empty queue
    logic need_srch;  // incoming request is a search on a non-empty queue
    logic match;      // current search entry equals the key
    logic last;       // current search entry is the rightmost one
    logic out_free;   // output register can take a result this cycle
  } dp_stat_t;

endpackage

[src/bdq_ram.sv]
// Generic single-port RAM with registered read
module bdq_ram #(
  parameter int WIDTH = bdq_pkg::DATA_W,
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

[src/bdq_ctrl.sv]
// Request sequencing state machine for the deque
module bdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bdq_pkg::dp_stat_t stat,
  output bdq_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_SRCH = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.accept = 1'b1;
          priority if (stat.need_read) state_nxt = S_READ;
          else if (stat.need_srch)     state_nxt = S_SRCH;
          else                         state_nxt = S_OUT;
        end
      end
      S_READ: begin
        cmd.read_done = 1'b1;
        state_nxt     = S_OUT;
      end
      S_SRCH: begin
        cmd.srch_addr = 1'b1;
        if (stat.match || stat.last) begin
          cmd.srch_done = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          cmd.srch_next = 1'b1;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[src/bdq_dp.sv]
// Deque datapath: ring pointers, entry store, search walk and result registers
module bdq_dp #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [bdq_pkg::OP_W-1:0]             in_operation,
  input  logic signed [bdq_pkg::DATA_W-1:0]    in_value,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [bdq_pkg::DATA_W-1:0]    out_data,
  output logic [bdq_pkg::ST_W-1:0]             out_status,
  output logic                                 out_found,
  output logic [$clog2(DEPTH+1)-1:0]           out_occupancy,
  input  bdq_pkg::dp_cmd_t                     cmd,
  output bdq_pkg::dp_stat_t                    stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // ring position of base + off, off in 0..DEPTH
  function automatic logic [AW-1:0] ring(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) sum = sum - SW'(DEPTH);
    return sum[AW-1:0];
  endfunction

  logic [AW-1:0]                     head_r;
  logic [CW-1:0]                     count_r;
  logic [bdq_pkg::OP_W-1:0]          op_r;
  logic signed [bdq_pkg::DATA_W-1:0] val_r;
  logic [CW-1:0]                     srch_r;
  logic signed [bdq_pkg::DATA_W-1:0] res_data_r;
  logic [bdq_pkg::ST_W-1:0]          res_status_r;
  logic                              res_found_r;
  logic                              out_valid_r;
  logic signed [bdq_pkg::DATA_W-1:0] out_data_r;
  logic [bdq_pkg::ST_W-1:0]          out_status_r;
  logic                              out_found_r;
  logic [CW-1:0]                     out_occ_r;

  logic                              full, empty;
  logic                              in_push, in_left, in_popk, in_srch;
  logic [AW-1:0]                     in_addr, srch_addr, ram_addr, left_head;
  logic                              ram_we;
  logic [bdq_pkg::DATA_W-1:0]        ram_rdata;
  logic [CW-1:0]                     srch_inc;

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);

  always_comb begin
    in_push = 1'b0;
    in_popk = 1'b0;
    in_left = 1'b0;
    in_srch = 1'b0;
    unique case (in_operation)
      bdq_pkg::OP_PUSH_LEFT:  begin in_push = 1'b1; in_left = 1'b1; end
      bdq_pkg::OP_PUSH_RIGHT: in_push = 1'b1;
      bdq_pkg::OP_POP_LEFT:   begin in_popk = 1'b1; in_left = 1'b1; end
      bdq_pkg::OP_POP_RIGHT:  in_popk = 1'b1;
      bdq_pkg::OP_PEEK_LEFT:  begin in_popk = 1'b1; in_left = 1'b1; end
      bdq_pkg::OP_PEEK_RIGHT: in_popk = 1'b1;
      bdq_pkg::OP_SEARCH:     in_srch = 1'b1;
      default: ;
    endcase
  end

  assign left_head = ring(head_r, CW'(DEPTH - 1));
  assign srch_inc  = srch_r + 1'b1;
  assign srch_addr = ring(head_r, srch_inc);

  always_comb begin
    priority if (in_push && in_left)      in_addr = left_head;
    else if (in_push)                     in_addr = ring(head_r, count_r);
    else if (in_popk && !in_left)         in_addr = ring(head_r, count_r - 1'b1);
    else                                  in_addr = head_r;
  end

  assign ram_addr = cmd.srch_addr ? srch_addr : in_addr;
  assign ram_we   = cmd.accept && in_push && !full;

  bdq_ram #(
    .WIDTH (bdq_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_value),
    .rdata (ram_rdata)
  );

  assign stat.need_read = in_popk && !empty;
  assign stat.need_srch = in_srch && !empty;
  assign stat.match     = ($signed(ram_rdata) == val_r);
  assign stat.last      = (srch_inc == count_r);
  assign stat.out_free  = !out_valid_r || out_ready;

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (ram_we) begin
      if (in_left) head_r <= left_head;
      count_r <= count_r + 1'b1;
    end else if (cmd.read_done &&
                 (op_r == bdq_pkg::OP_POP_LEFT || op_r == bdq_pkg::OP_POP_RIGHT)) begin
      if (op_r == bdq_pkg::OP_POP_LEFT) head_r <= ring(head_r, CW'(1));
      count_r <= count_r - 1'b1;
    end
  end

  // request and result staging
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r        <= in_operation;
      val_r       <= in_value;
      srch_r      <= '0;
      res_found_r <= 1'b0;
      if (in_popk && empty) begin
        res_data_r   <= bdq_pkg::EMPTY_DATA;
        res_status_r <= bdq_pkg::ST_EMPTY;
      end else begin
        res_data_r   <= '0;
        res_status_r <= (in_push && full) ? bdq_pkg::ST_FULL : bdq_pkg::ST_OK;
      end
    end
    if (cmd.read_done) res_data_r <= $signed(ram_rdata);
    if (cmd.srch_next) srch_r <= srch_inc;
    if (cmd.srch_done) res_found_r <= stat.match;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r   <= res_data_r;
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_occ_r    <= count_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign out_status    = out_status_r;
  assign out_found     = out_found_r;
  assign out_occupancy = out_occ_r;

endmodule

[src/bounded_double_ended_queue.sv]
// Bounded double-ended queue of signed 32-bit values with search (top level)
// Each request is one of push left/right, pop left/right, peek left/right or
// search, and returns one result with data, status, found flag and occupancy.
// Elements live in a single-port ring RAM of DEPTH entries. Push, full/empty
// rejects and unused codes go from acceptance to the output state, pop and
// peek first pass through one registered RAM read, and a search compares k
// entries (at most DEPTH), reading one entry per cycle through the single
// RAM port. A new request is taken only once the previous one has reached
// the output register; a result may wait there while the next request is
// already being worked on. No clearing pass after reset: unwritten entries
// are never read.
module bounded_double_ended_queue #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bdq_pkg::OP_W-1:0]          in_operation,
  input  logic signed [bdq_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bdq_pkg::DATA_W-1:0] out_data,
  output logic [bdq_pkg::ST_W-1:0]          out_status,
  output logic                              out_found,
  output logic [$clog2(DEPTH+1)-1:0]        out_occupancy
);

  bdq_pkg::dp_cmd_t  cmd;
  bdq_pkg::dp_stat_t stat;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_operation  (in_operation),
    .in_value      (in_value),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .out_status    (out_status),
    .out_found     (out_found),
    .out_occupancy (out_occupancy),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

[src/bdq_checker.sv]
// Port-level checker for the bounded double-ended queue, bound to the top level
`include "bounded_double_ended_queue_macros.svh"

module bdq_checker #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [bdq_pkg::DATA_W-1:0] out_data,
  input logic [bdq_pkg::ST_W-1:0]          out_status,
  input logic                              out_found,
  input logic [$clog2(DEPTH+1)-1:0]        out_occupancy
);

  `BDQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_data) && $stable(out_occupancy), "result changed while stalled")

  `BDQ_ASSERT_NOW(a_occ_range, clk, rst_n, out_valid,
    out_occupancy <= ($clog2(DEPTH+1))'(DEPTH), "occupancy beyond depth")

  `BDQ_ASSERT_NOW(a_full_rej, clk, rst_n, out_valid && out_status == bdq_pkg::ST_FULL,
    out_occupancy == ($clog2(DEPTH+1))'(DEPTH) && out_data == '0 && !out_found,
    "full reject with wrong fields")

  `BDQ_ASSERT_NOW(a_empty_rej, clk, rst_n, out_valid && out_status == bdq_pkg::ST_EMPTY,
    out_occupancy == '0 && out_data == bdq_pkg::EMPTY_DATA && !out_found,
    "empty reject with wrong fields")

  `BDQ_ASSERT_NOW(a_found_ok, clk, rst_n, out_valid && out_found,
    out_status == bdq_pkg::ST_OK && out_occupancy != '0 && out_data == '0,
    "hit reported on a non-search result")

endmodule

bind bounded_double_ended_queue bdq_checker #(.DEPTH(DEPTH)) u_bdq_checker (.*);

[dv/tb_bounded_double_ended_queue.sv]
// Self-checking testbench for the bounded double-ended queue with search
`timescale 1ns / 1ps

module tb_bounded_double_ended_queue;

  localparam int DEPTH = bdq_pkg::DEPTH_DEF;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam logic [bdq_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [bdq_pkg::OP_W-1:0]          op;
    logic signed [bdq_pkg::DATA_W-1:0] value;
  } deque_req_t;

  typedef struct packed {
    logic signed [bdq_pkg::DATA_W-1:0] data;
    logic [bdq_pkg::ST_W-1:0]          status;
    logic                              found;
    logic [OCC_W-1:0]                  occupancy;
  } deque_result_t;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} burst_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [bdq_pkg::OP_W-1:0] in_operation = bdq_pkg::OP_PUSH_LEFT;
  logic signed [bdq_pkg::DATA_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [bdq_pkg::DATA_W-1:0] out_data;
  logic [bdq_pkg::ST_W-1:0] out_status;
  logic out_found;
  logic [OCC_W-1:0] out_occupancy;

  deque_req_t pending_requests[$];
  deque_result_t expected_results[$];
  int errors = 0;
  int unsigned cyc = 0;
  logic steady;

  // shadow copy of the deque
  logic signed [bdq_pkg::DATA_W-1:0] ring [DEPTH];
  int head = 0;
  int fill = 0;

  logic signed [bdq_pkg::DATA_W-1:0] value_pool [8] = '{
    32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1, 32'sd1, 32'sd2, 32'sd3, 32'sd5
  };

  bounded_double_ended_queue u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .out_status   (out_status),
    .out_found    (out_found),
    .out_occupancy(out_occupancy)
  );

  always #4 clk = ~clk;

  always @(posedge clk) cyc <= cyc + 1;
  assign steady = (cyc >= 1500) && (cyc < 3000);

  function automatic deque_result_t deque_apply(input deque_req_t rq);
    deque_result_t r;
    r.data      = '0;
    r.status    = bdq_pkg::ST_OK;
    r.found     = 1'b0;
    r.occupancy = '0;
    case (rq.op)
      bdq_pkg::OP_PUSH_LEFT, bdq_pkg::OP_PUSH_RIGHT: begin
        if (fill >= DEPTH) begin
          r.status = bdq_pkg::ST_FULL;
        end else if (rq.op == bdq_pkg::OP_PUSH_LEFT) begin
          head = (head + DEPTH - 1) % DEPTH;
          ring[head] = rq.value;
          fill++;
        end else begin
          ring[(head + fill) % DEPTH] = rq.value;
          fill++;
        end
      end
      bdq_pkg::OP_POP_LEFT, bdq_pkg::OP_POP_RIGHT,
      bdq_pkg::OP_PEEK_LEFT, bdq_pkg::OP_PEEK_RIGHT: begin
        if (fill == 0) begin
          r.data   = bdq_pkg::EMPTY_DATA;
          r.status = bdq_pkg::ST_EMPTY;
        end else if (rq.op == bdq_pkg::OP_POP_LEFT || rq.op == bdq_pkg::OP_PEEK_LEFT) begin
          r.data = ring[head];
          if (rq.op == bdq_pkg::OP_POP_LEFT) begin
            head = (head + 1) % DEPTH;
            fill--;
          end
        end else begin
          r.data = ring[(head + fill - 1) % DEPTH];
          if (rq.op == bdq_pkg::OP_POP_RIGHT) fill--;
        end
      end
      bdq_pkg::OP_SEARCH: begin
        for (int i = 0; i < fill; i++) begin
          if (ring[(head + i) % DEPTH] == rq.value) r.found = 1'b1;
        end
      end
      default: ;
    endcase
    r.occupancy = fill[OCC_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic add_req(input logic [bdq_pkg::OP_W-1:0] op,
                         input logic signed [bdq_pkg::DATA_W-1:0] value);
    deque_req_t rq;
    rq.op    = op;
    rq.value = value;
    pending_requests.push_back(rq);
  endtask

  // request driver
  always @(posedge clk) begin
    deque_req_t nxt;
    deque_req_t taken;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        taken.op    = in_operation;
        taken.value = in_value;
        expected_results.push_back(deque_apply(taken));
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
          nxt = pending_requests.pop_front();
          in_valid     <= 1'b1;
          in_operation <= nxt.op;
          in_value     <= nxt.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    deque_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result data %0d status %0d", out_data,
                                    out_status));
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want.data)
            report_mismatch($sformatf("data %0d, want %0d", out_data, want.data));
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_found !== want.found)
            report_mismatch($sformatf("found %0b, want %0b", out_found, want.found));
          if (out_occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy %0d, want %0d", out_occupancy,
                                      want.occupancy));
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 30);
    end
  end

  initial begin
    int n;
    int burst;
    burst_mode_t mode;
    logic [bdq_pkg::OP_W-1:0] op;
    logic signed [bdq_pkg::DATA_W-1:0] v;

    // empty queue, unused code, extremes, last element leaving from either end
    add_req(bdq_pkg::OP_POP_LEFT, 32'sd7);
    add_req(bdq_pkg::OP_POP_RIGHT, 32'sd7);
    add_req(bdq_pkg::OP_PEEK_LEFT, 32'sd7);
    add_req(bdq_pkg::OP_PEEK_RIGHT, 32'sd7);
    add_req(bdq_pkg::OP_SEARCH, 32'sd0);
    add_req(OP_UNUSED, 32'sh5A5A_A5A5);
    add_req(bdq_pkg::OP_PUSH_LEFT, 32'sh8000_0000);
    add_req(bdq_pkg::OP_PUSH_RIGHT, 32'sh7FFF_FFFF);
    add_req(bdq_pkg::OP_PEEK_LEFT, 32'sd0);
    add_req(bdq_pkg::OP_PEEK_RIGHT, 32'sd0);
    add_req(bdq_pkg::OP_SEARCH, 32'sh8000_0000);
    add_req(bdq_pkg::OP_SEARCH, 32'sd0);
    add_req(OP_UNUSED, -32'sd1);
    add_req(bdq_pkg::OP_POP_RIGHT, 32'sd0);
    add_req(bdq_pkg::OP_POP_LEFT, 32'sd0);
    add_req(bdq_pkg::OP_PUSH_RIGHT, -32'sd1);
    add_req(bdq_pkg::OP_POP_RIGHT, 32'sd0);
    add_req(bdq_pkg::OP_PUSH_LEFT, 32'sd0);
    add_req(bdq_pkg::OP_POP_LEFT, 32'sd0);
    add_req(bdq_pkg::OP_PEEK_RIGHT, 32'sd0);

    // bursts biased towards filling, draining or mixed traffic
    n = 0;
    while (n < 600) begin
      mode  = (n == 0) ? MODE_FILL : burst_mode_t'($urandom_range(2));
      burst = $urandom_range(20, 50);
      for (int k = 0; k < burst; k++) begin
        case (mode)
          MODE_FILL: begin
            if ($urandom_range(99) < 75)
              op = $urandom_range(1) ? bdq_pkg::OP_PUSH_RIGHT : bdq_pkg::OP_PUSH_LEFT;
            else
              op = bdq_pkg::OP_W'($urandom_range(2, 7));
          end
          MODE_DRAIN: begin
            if ($urandom_range(99) < 70)
              op = $urandom_range(1) ? bdq_pkg::OP_POP_RIGHT : bdq_pkg::OP_POP_LEFT;
            else
              op = bdq_pkg::OP_W'($urandom_range(7));
          end
          default: op = bdq_pkg::OP_W'($urandom_range(7));
        endcase
        v = $urandom_range(1) ? bdq_pkg::DATA_W'($urandom) : value_pool[$urandom_range(7)];
        add_req(op, v);
        n++;
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_bounded_double_ended_queue passed");
    end else begin
      $display("tb_bounded_double_ended_queue failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_bounded_double_ended_queue failed");
    $finish;
  end

endmodule
